// ----- src/assert_macros.svh -----
// assertion macros for the message cache
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// clocked check, disabled while reset is active
`define AMC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check that also holds during reset
`define AMC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AMC_ASSERT(lbl, clk, rst_n, prop, msg)
`define AMC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- src/amc_pkg.sv -----
`default_nettype none

package amc_pkg;

    localparam int TAG_W   = 31;
    localparam int WORD_W  = 32;
    localparam int STAMP_W = 32;
    localparam int SLOT_W  = 4;

    // request codes
    localparam logic CMD_STORE    = 1'b0;
    localparam logic CMD_RETRIEVE = 1'b1;

    // one stored entry
    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [WORD_W-1:0]  payload;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_WRITE  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

endpackage

`default_nettype wire

// ----- src/amc_entry_ram.sv -----
`default_nettype none

module amc_entry_ram #(
    parameter  int DEPTH  = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic                aclk,
    input  wire logic                wr_en,
    input  wire logic [ADDR_W-1:0]   wr_addr,
    input  wire amc_pkg::entry_t     wr_data,
    input  wire logic                rd_en,
    input  wire logic [ADDR_W-1:0]   rd_addr,
    output amc_pkg::entry_t          rd_data
);
    import amc_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- src/assoc_message_cache_oldest_replace_top.sv -----
// channel | ports                                            | dir
// request | s_valid s_ready s_command s_message_id           | in
//         | s_message_payload                                |
// result  | m_valid m_ready m_found m_read_payload m_slot_used | out
//
// one request at a time; entries live in a single-port-read ram, one slot read per cycle
// store with a free slot: straight to the write, then on to the result
// store with all slots used: a stamp scan over every slot, then the write into the oldest
// retrieve: a scan up to the fill count that stops at the first hit; no scan when empty
// reset clears the fill count and stamp counter; slots fill in order, so no ram clear
// a result waits in the output register; the next request is taken meanwhile
`default_nettype none

module assoc_message_cache_oldest_replace_top #(
    parameter int NUM_SLOTS = 16
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic                        s_command,
    input  wire logic [amc_pkg::TAG_W-1:0]   s_message_id,
    input  wire logic [amc_pkg::WORD_W-1:0]  s_message_payload,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic                             m_found,
    output logic [amc_pkg::WORD_W-1:0]       m_read_payload,
    output logic [amc_pkg::SLOT_W-1:0]       m_slot_used
);
    import amc_pkg::*;

    localparam int IDX_W = $clog2(NUM_SLOTS);
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(NUM_SLOTS);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [STAMP_W-1:0] stamp_reg, stamp_next;

    // latched request
    logic               cmd_reg, cmd_next;
    logic [TAG_W-1:0]   id_reg, id_next;
    logic [WORD_W-1:0]  pay_reg, pay_next;

    // scan control
    logic [CNT_W-1:0]   iss_reg, iss_next;
    logic [CNT_W-1:0]   limit_reg, limit_next;
    logic               rd_valid_reg, rd_valid_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [STAMP_W-1:0] best_stamp_reg, best_stamp_next;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;

    // pending result
    logic               res_found_reg, res_found_next;
    logic [WORD_W-1:0]  res_pay_reg, res_pay_next;
    logic [IDX_W-1:0]   res_idx_reg, res_idx_next;

    // output register
    logic               m_valid_reg, m_valid_next;
    logic               m_found_reg, m_found_next;
    logic [WORD_W-1:0]  m_pay_reg, m_pay_next;
    logic [IDX_W-1:0]   m_idx_reg, m_idx_next;

    // ram port
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    entry_t             wr_data;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    entry_t             rd_data;

    logic               accept;
    logic               last_slot;
    logic               take_new;
    logic [IDX_W+SLOT_W-1:0] slot_ext;

    // terms for the checks
    logic               free_store;
    logic [STAMP_W-1:0] stamp_inc;
    logic               res_out;
    logic [CNT_W-1:0]   idx_ext;

    amc_entry_ram #(
        .DEPTH (NUM_SLOTS)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // scan read issue, one slot per cycle
    assign rd_en   = (state_reg == ST_SCAN) && (iss_reg < limit_reg);
    assign rd_addr = iss_reg[IDX_W-1:0];

    assign last_slot = (CNT_W'(rd_idx_reg) + CNT_W'(1)) == limit_reg;
    assign take_new  = (rd_idx_reg == '0) || (rd_data.stamp < best_stamp_reg);

    // entry write, slot comes from the pending result
    assign wr_en         = (state_reg == ST_WRITE);
    assign wr_addr       = res_idx_reg;
    assign wr_data.tag     = id_reg;
    assign wr_data.payload = pay_reg;
    assign wr_data.stamp   = stamp_reg;

    // sequencer
    always_comb begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        stamp_next      = stamp_reg;
        cmd_next        = cmd_reg;
        id_next         = id_reg;
        pay_next        = pay_reg;
        iss_next        = iss_reg;
        limit_next      = limit_reg;
        rd_valid_next   = rd_en;
        rd_idx_next     = rd_addr;
        best_stamp_next = best_stamp_reg;
        best_idx_next   = best_idx_reg;
        res_found_next  = res_found_reg;
        res_pay_next    = res_pay_reg;
        res_idx_next    = res_idx_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_found_next    = m_found_reg;
        m_pay_next      = m_pay_reg;
        m_idx_next      = m_idx_reg;

        if (rd_en) begin
            iss_next = iss_reg + CNT_W'(1);
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd_next     = s_command;
                    id_next      = s_message_id;
                    pay_next     = s_message_payload;
                    iss_next     = '0;
                    res_found_next = 1'b0;
                    res_pay_next = '0;
                    res_idx_next = '0;
                    if (s_command == CMD_STORE) begin
                        if (fill_reg != FULL_CNT) begin
                            // free slot is the next one in fill order
                            res_idx_next = fill_reg[IDX_W-1:0];
                            state_next   = ST_WRITE;
                        end else begin
                            limit_next = FULL_CNT;
                            state_next = ST_SCAN;
                        end
                    end else if (fill_reg == '0) begin
                        state_next = ST_FINISH;
                    end else begin
                        limit_next = fill_reg;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (rd_valid_reg) begin
                    if (cmd_reg == CMD_STORE) begin
                        // running minimum of stamps, first slot wins ties
                        if (take_new) begin
                            best_stamp_next = rd_data.stamp;
                            best_idx_next   = rd_idx_reg;
                        end
                        if (last_slot) begin
                            res_idx_next = take_new ? rd_idx_reg : best_idx_reg;
                            state_next   = ST_WRITE;
                        end
                    end else if (rd_data.tag == id_reg) begin
                        res_found_next = 1'b1;
                        res_pay_next   = rd_data.payload;
                        res_idx_next   = rd_idx_reg;
                        state_next     = ST_FINISH;
                    end else if (last_slot) begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_WRITE: begin
                stamp_next     = stamp_reg + STAMP_W'(1);
                res_found_next = 1'b1;
                res_pay_next   = '0;
                if (fill_reg != FULL_CNT) begin
                    fill_next = fill_reg + CNT_W'(1);
                end
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                // hand over once the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_found_next = res_found_reg;
                    m_pay_next   = res_pay_reg;
                    m_idx_next   = res_idx_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            fill_reg     <= '0;
            stamp_reg    <= '0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            stamp_reg    <= stamp_next;
            rd_valid_reg <= rd_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        id_reg         <= id_next;
        pay_reg        <= pay_next;
        iss_reg        <= iss_next;
        limit_reg      <= limit_next;
        rd_idx_reg     <= rd_idx_next;
        best_stamp_reg <= best_stamp_next;
        best_idx_reg   <= best_idx_next;
        res_found_reg  <= res_found_next;
        res_pay_reg    <= res_pay_next;
        res_idx_reg    <= res_idx_next;
        m_found_reg    <= m_found_next;
        m_pay_reg      <= m_pay_next;
        m_idx_reg      <= m_idx_next;
    end

    // slot index carried on the low bits only
    assign slot_ext = {{SLOT_W{1'b0}}, m_idx_reg};

    assign m_valid        = m_valid_reg;
    assign m_found        = m_found_reg;
    assign m_read_payload = m_pay_reg;
    assign m_slot_used    = slot_ext[SLOT_W-1:0];

    // check terms
    assign free_store = accept && (s_command == CMD_STORE) && (fill_reg != FULL_CNT);
    assign stamp_inc  = stamp_reg + STAMP_W'(1);
    assign res_out    = m_valid_reg && m_found_reg;
    assign idx_ext    = CNT_W'(m_idx_reg);

    // checks
    `include "assert_macros.svh"

    `AMC_ASSERT(a_fill_bound, aclk, aresetn, fill_reg <= FULL_CNT, "fill count above slot count")
    `AMC_ASSERT(a_free_store, aclk, aresetn, free_store |=> wr_en, "free slot store not written")
    `AMC_ASSERT(a_stamp_step, aclk, aresetn, wr_en |=> (stamp_reg == $past(stamp_inc)), "stamp stuck")
    `AMC_ASSERT(a_slot_filled, aclk, aresetn, res_out |-> (idx_ext < fill_reg), "slot not filled")

endmodule

`default_nettype wire
